// ===== sv/sorted_multiset_table_assert.svh =====
// Assertion macros shared by the sorted multiset table RTL.
// Depends on nothing; included by sorted_multiset_table.sv for its concurrent checks.
`ifndef SORTED_MULTISET_TABLE_ASSERT_SVH
`define SORTED_MULTISET_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low
`define SMT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sorted_multiset_table: check failed");

// Next-cycle implication, disabled while reset is low
`define SMT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sorted_multiset_table: check failed");

`endif

// ===== sv/smt_pkg.sv =====
// Package for the sorted multiset table: sizes, op and status codes,
// and the structs that run between neighboring cells. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package smt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int DATA_W      = 32;
    localparam int OUT_CNT_W   = 5;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Op codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_COUNT  = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    // Broadcast command to every cell
    typedef struct packed {
        logic                     ins;
        logic                     del;
        logic signed [DATA_W-1:0] value;
    } t_cmd;

    // Data a cell hands to its right neighbor
    typedef struct packed {
        logic signed [DATA_W-1:0] entry;
        logic                     valid;
        logic                     take;
        logic                     tok;
        logic [CNT_W-1:0]         cnt;
    } t_fwd;

    // Data a cell hands to its left neighbor
    typedef struct packed {
        logic signed [DATA_W-1:0] entry;
        logic                     valid;
    } t_bwd;

    // Fit an internal count onto the 5-bit result ports
    function automatic logic [OUT_CNT_W-1:0] to_out(input logic [CNT_W-1:0] c);
        logic [31:0] w;
        w = 32'(c);
        return w[OUT_CNT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== sv/smt_cell.sv =====
// One cell of the sorted table: holds one entry and its valid bit, shifts on
// insert/delete, and passes the match-count token on to its right neighbor.
// Depends on smt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module smt_cell (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire smt_pkg::t_cmd i_cmd,
    input  wire smt_pkg::t_fwd i_prev,
    input  wire smt_pkg::t_bwd i_next,
    output smt_pkg::t_fwd      o_fwd,
    output smt_pkg::t_bwd      o_bwd
);

    logic signed [smt_pkg::DATA_W-1:0] r_entry, n_entry;
    logic                              r_valid, n_valid;
    logic                              r_tok;
    logic [smt_pkg::CNT_W-1:0]         r_cnt, n_cnt;
    logic                              lt, take, eq, ge;

    // Local compares against the broadcast value
    assign lt   = r_valid && (i_cmd.value < r_entry);
    assign take = !r_valid || lt;
    // entry at or above the value: from the first match onward in a sorted row
    assign ge   = r_valid && !(r_entry < i_cmd.value);
    assign eq   = r_valid && (r_entry == i_cmd.value);

    assign o_fwd = '{entry: r_entry, valid: r_valid, take: take, tok: r_tok, cnt: r_cnt};
    assign o_bwd = '{entry: r_entry, valid: r_valid};

    // Insert shifts right from the insert point; delete shifts left from the match
    always_comb begin
        n_entry = r_entry;
        n_valid = r_valid;
        if (i_cmd.ins) begin
            if (i_prev.take) begin
                n_entry = i_prev.entry;
                n_valid = i_prev.valid;
            end else if (take) begin
                n_entry = i_cmd.value;
                n_valid = 1'b1;
            end
        end else if (i_cmd.del && ge) begin
            n_entry = i_next.entry;
            n_valid = i_next.valid;
        end
    end

    // Running match count rides along with the token
    assign n_cnt = i_prev.cnt + smt_pkg::CNT_W'(eq);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tok   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_tok   <= i_prev.tok;
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_cnt   <= n_cnt;
    end

endmodule

`default_nettype wire

// ===== sv/sorted_multiset_table.sv =====
// Op 3 strobes in the cycle after the accepting edge; insert first passes through
// S_INS, and count and delete pass through S_SCAN while the count token walks
// the cell chain one cell per clock. busy is high until the result strobes, so
// a new transaction is taken only once the previous one has finished. The receiver
// cannot stall. Synchronous active-low reset empties the table, no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module sorted_multiset_table (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output      logic                              busy,
    input  wire logic [1:0]                        i_op,
    input  wire logic signed [smt_pkg::DATA_W-1:0] i_value,
    output      logic                              o_done,
    output      logic [1:0]                        o_status,
    output      logic [smt_pkg::OUT_CNT_W-1:0]     o_match_count,
    output      logic [smt_pkg::OUT_CNT_W-1:0]     o_fill_level
);

`include "sorted_multiset_table_assert.svh"

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_INS  = 3'b010,
        S_SCAN = 3'b100
    } t_state;

    localparam int D = smt_pkg::TABLE_DEPTH;
    localparam logic [smt_pkg::CNT_W-1:0] FULL_CNT = smt_pkg::CNT_W'(D);

    t_state                            r_state, n_state;
    logic [1:0]                        r_op, n_op;
    logic signed [smt_pkg::DATA_W-1:0] r_val, n_val;
    logic                              r_launch, n_launch;
    logic [smt_pkg::CNT_W-1:0]         r_fill, n_fill;
    logic                              r_done, n_done;
    logic [1:0]                        r_status, n_status;
    logic [smt_pkg::CNT_W-1:0]         r_mcnt, n_mcnt;
    logic [smt_pkg::CNT_W-1:0]         r_ofill, n_ofill;

    logic                              accept, full, empty, scan_done;
    logic [smt_pkg::CNT_W-1:0]         total;
    logic [D-1:0]                      valid_vec;
    smt_pkg::t_cmd                     cmd;
    smt_pkg::t_fwd                     fwd     [D];
    smt_pkg::t_bwd                     bwd     [D];
    smt_pkg::t_fwd                     prev_in [D];
    smt_pkg::t_bwd                     next_in [D];

    assign busy      = (r_state != S_IDLE);
    assign accept    = start && !busy;
    assign full      = (r_fill == FULL_CNT);
    assign empty     = (r_fill == '0);
    assign scan_done = fwd[D-1].tok;
    assign total     = fwd[D-1].cnt;

    // Command broadcast to the chain
    assign cmd.value = r_val;
    assign cmd.ins   = (r_state == S_INS) && !full;
    assign cmd.del   = (r_state == S_SCAN) && scan_done && (r_op == smt_pkg::OP_DELETE)
                       && (total != '0);

    // Cell chain
    for (genvar g = 0; g < D; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign prev_in[g] = '{entry: '0, valid: 1'b0, take: 1'b0, tok: r_launch,
                                  cnt: '0};
        end else begin : g_body
            assign prev_in[g] = fwd[g-1];
        end
        if (g == D - 1) begin : g_tail
            assign next_in[g] = '{entry: '0, valid: 1'b0};
        end else begin : g_inner
            assign next_in[g] = bwd[g+1];
        end
        assign valid_vec[g] = bwd[g].valid;

        smt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (cmd),
            .i_prev  (prev_in[g]),
            .i_next  (next_in[g]),
            .o_fwd   (fwd[g]),
            .o_bwd   (bwd[g])
        );
    end

    // Sequencer and result formation
    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_val    = r_val;
        n_launch = 1'b0;
        n_fill   = r_fill;
        n_done   = 1'b0;
        n_status = r_status;
        n_mcnt   = r_mcnt;
        n_ofill  = r_ofill;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op  = i_op;
                    n_val = i_value;
                    case (i_op)
                        smt_pkg::OP_INSERT: n_state = S_INS;
                        smt_pkg::OP_COUNT, smt_pkg::OP_DELETE: begin
                            n_state  = S_SCAN;
                            n_launch = 1'b1;
                        end
                        default: begin
                            n_done   = 1'b1;
                            n_status = smt_pkg::ST_OK;
                            n_mcnt   = '0;
                            n_ofill  = r_fill;
                        end
                    endcase
                end
            end
            S_INS: begin
                n_done  = 1'b1;
                n_mcnt  = '0;
                n_state = S_IDLE;
                if (full) begin
                    n_status = smt_pkg::ST_FULL;
                    n_ofill  = r_fill;
                end else begin
                    n_status = smt_pkg::ST_OK;
                    n_fill   = r_fill + smt_pkg::CNT_W'(1);
                    n_ofill  = n_fill;
                end
            end
            S_SCAN: begin
                if (scan_done) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                    n_mcnt  = (r_op == smt_pkg::OP_COUNT) ? total : '0;
                    if (empty) begin
                        n_status = smt_pkg::ST_EMPTY;
                    end else if (total == '0) begin
                        n_status = smt_pkg::ST_NOT_FOUND;
                    end else begin
                        n_status = smt_pkg::ST_OK;
                    end
                    if (cmd.del) begin
                        n_fill = r_fill - smt_pkg::CNT_W'(1);
                    end
                    n_ofill = n_fill;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_launch <= 1'b0;
            r_fill   <= '0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_launch <= n_launch;
            r_fill   <= n_fill;
            r_done   <= n_done;
        end
    end

    // Transaction payload and result payload, no reset
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_val    <= n_val;
        r_status <= n_status;
        r_mcnt   <= n_mcnt;
        r_ofill  <= n_ofill;
    end

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_match_count = smt_pkg::to_out(r_mcnt);
    assign o_fill_level  = smt_pkg::to_out(r_ofill);

    // Checks
    `SMT_ASSERT_IMP(a_fill_matches_cells, i_clk, i_rst_n, 1'b1, $countones(valid_vec) == 32'(r_fill))
    `SMT_ASSERT_IMP(a_done_when_idle, i_clk, i_rst_n, r_done, r_state == S_IDLE)
    `SMT_ASSERT_IMP(a_full_status, i_clk, i_rst_n, r_done && (r_status == smt_pkg::ST_FULL), full)
    `SMT_ASSERT_NXT(a_insert_next, i_clk, i_rst_n, accept && (i_op == smt_pkg::OP_INSERT), r_state == S_INS)

endmodule

`default_nettype wire
